@@ src/balance_cascade_controller_unit_macros.svh @@
// Assertion macros for the balance cascade controller.
// Included by the top level; no other dependencies.
`ifndef BALANCE_CASCADE_CONTROLLER_UNIT_MACROS_SVH
`define BALANCE_CASCADE_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTH
`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bcc: same-cycle check failed");
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bcc: next-cycle check failed");
`else
`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/bcc_pkg.sv @@
// Shared types and constants for the balance cascade controller.
// No dependencies; imported by every module of the block.
package bcc_pkg;

	localparam int AngleW  = 17;
	localparam int RateW   = 24;
	localparam int PwmW    = 24;
	localparam int DriveW  = 32;
	localparam int GainW   = 32;
	localparam int LimitW  = 30;
	localparam int OffsetW = 17;
	localparam int AvgW    = 40;
	localparam int IntW    = 31;
	localparam int Lr3W    = 27;
	localparam int NumW    = 44;
	localparam int MagW    = 48;
	localparam int OpW     = 33;
	localparam int ProdW   = 66;
	localparam int TargetW = 21;
	localparam int TiltW   = 26;
	localparam int Err16W  = 25;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	// Byte-wide long division by ten.
	localparam int DivSteps = MagW / 8;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam logic [12:0] Recip10 = 13'd6554;

	localparam logic signed [AngleW-1:0]  TiltLimit   = 17'sd15360;
	localparam logic signed [TargetW-1:0] TargetLimit = 21'sd983040;

	localparam logic signed [GainW-1:0]   SpeedGainPReset = 32'sd393216;
	localparam logic signed [GainW-1:0]   SpeedGainIReset = 32'sd1966;
	localparam logic [LimitW-1:0]         IntLimitReset   = 30'd500000;
	localparam logic signed [GainW-1:0]   TiltGainPReset  = 32'sd29491200;
	localparam logic signed [GainW-1:0]   TiltGainDReset  = -32'sd196608000;
	localparam logic signed [OffsetW-1:0] TiltOffsetReset = 17'sd1792;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SPEED_GAIN_P = 3'd0,
		REG_SPEED_GAIN_I = 3'd1,
		REG_INT_LIMIT    = 3'd2,
		REG_TILT_GAIN_P  = 3'd3,
		REG_TILT_GAIN_D  = 3'd4,
		REG_TILT_OFFSET  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [AngleW-1:0] pitch_angle;
		logic signed [RateW-1:0]  pitch_rate;
		logic signed [PwmW-1:0]   left_pwm;
		logic signed [PwmW-1:0]   right_pwm;
	} item_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive;
		logic                     tipped_over;
	} result_t;

	typedef struct packed {
		logic signed [GainW-1:0]   speed_gain_p;
		logic signed [GainW-1:0]   speed_gain_i;
		logic [LimitW-1:0]         integral_limit;
		logic signed [GainW-1:0]   tilt_gain_p;
		logic signed [GainW-1:0]   tilt_gain_d;
		logic signed [OffsetW-1:0] tilt_offset;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_NUM,
		OP_MAG,
		OP_DIV,
		OP_AVG,
		OP_MUL_SP,
		OP_MUL_SI,
		OP_TGT,
		OP_TERR,
		OP_MUL_TP,
		OP_MUL_TD,
		OP_SUM,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic tipped;
	} dp_status_t;

endpackage

@@ src/bcc_cfg.sv @@
// Configuration register bank of the balance cascade controller.
// Depends on bcc_pkg for the register layout and reset values.
module bcc_cfg import bcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_gain_p   <= SpeedGainPReset;
			cfg_q.speed_gain_i   <= SpeedGainIReset;
			cfg_q.integral_limit <= IntLimitReset;
			cfg_q.tilt_gain_p    <= TiltGainPReset;
			cfg_q.tilt_gain_d    <= TiltGainDReset;
			cfg_q.tilt_offset    <= TiltOffsetReset;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SPEED_GAIN_P: cfg_q.speed_gain_p   <= $signed(cfg_data);
				REG_SPEED_GAIN_I: cfg_q.speed_gain_i   <= $signed(cfg_data);
				REG_INT_LIMIT:    cfg_q.integral_limit <= cfg_data[LimitW-1:0];
				REG_TILT_GAIN_P:  cfg_q.tilt_gain_p    <= $signed(cfg_data);
				REG_TILT_GAIN_D:  cfg_q.tilt_gain_d    <= $signed(cfg_data);
				REG_TILT_OFFSET:  cfg_q.tilt_offset    <= $signed(cfg_data[OffsetW-1:0]);
				default: ;
			endcase
		end
	end

endmodule

@@ src/bcc_dp.sv @@
// Datapath of the balance cascade controller: speed filter, divide by ten,
// shared 33x33 multiplier, PI/PD accumulation and output register. Uses bcc_pkg.
module bcc_dp import bcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	input  item_t      item,
	input  cfg_t       cfg,
	output dp_status_t status,
	output result_t    result
);

	// Item registers
	logic signed [AngleW-1:0] angle_q;
	logic signed [RateW-1:0]  rate_q;
	logic signed [Lr3W-1:0]   lr3_q;
	logic                     tipped_q;

	// Speed filter and divider
	logic signed [NumW-1:0]   num_q;
	logic                     neg_q;
	logic [MagW-1:0]          mag_q;
	logic [3:0]               rem_q;
	logic [AvgW-1:0]          quot_q;

	// Controller state
	logic signed [AvgW-1:0]   avg_q;
	logic signed [IntW-1:0]   integral_q;

	// Work registers
	logic signed [OpW-1:0]    err8_q;
	logic signed [Err16W-1:0] err16_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [ProdW-1:0]  acc_q;
	logic signed [TargetW-1:0] target_q;
	logic signed [TiltW-1:0]  tilt_q;
	result_t                  result_q;

	logic signed [PwmW:0]     lr;
	logic signed [Lr3W-1:0]   lr3;
	logic                     tipped_now;
	logic signed [NumW-1:0]   num;
	logic signed [MagW-1:0]   num48;
	logic [11:0]              dx;
	logic [23:0]              qprod;
	logic [7:0]               qdig;
	logic [11:0]              drem;
	logic [AvgW:0]            q_r8;
	logic [AvgW:0]            q_r16;
	logic signed [OpW-1:0]    m8;
	logic signed [Err16W-1:0] m16;
	logic signed [OpW-1:0]    mul_a;
	logic signed [OpW-1:0]    mul_b;
	logic signed [ProdW-1:0]  mul_p;
	logic signed [ProdW-1:0]  p_rnd;
	logic signed [ProdW-1:0]  t_sum;
	logic signed [IntW+1:0]   i_sum;
	logic signed [IntW+1:0]   i_lim;
	logic signed [ProdW-1:0]  a_rnd;
	logic signed [ProdW-1:0]  a_sh;
	logic signed [DriveW-1:0] drive_sat;

	assign status.tipped = tipped_q;
	assign result = result_q;

	always_comb begin
		lr = PwmW'(0) + {item.left_pwm[PwmW-1], item.left_pwm}
			+ {item.right_pwm[PwmW-1], item.right_pwm};
		lr3 = (Lr3W'(lr) <<< 1) + Lr3W'(lr);
		tipped_now = (item.pitch_angle > TiltLimit) || (item.pitch_angle < -TiltLimit);

		// 7*avg + 3*(l+r)*2^15, the numerator of the speed filter.
		num = (NumW'(avg_q) <<< 3) - NumW'(avg_q) + (NumW'(lr3_q) <<< 15);
		num48 = MagW'(num_q);

		// One quotient byte per step; the reciprocal is exact for dx below 2560.
		dx = {rem_q, mag_q[MagW-1 -: 8]};
		qprod = 24'(dx) * 24'(Recip10);
		qdig = qprod[23:16];
		drem = dx - 12'(qdig) * 12'd10;

		q_r8 = {1'b0, quot_q} + (AvgW+1)'(128);
		q_r16 = {1'b0, quot_q} + (AvgW+1)'(32768);
		m8 = $signed(q_r8[AvgW:8]);
		m16 = $signed(q_r16[AvgW:16]);

		case (cmd.op)
			OP_MUL_SP: begin
				mul_a = err8_q;
				mul_b = OpW'(cfg.speed_gain_p);
			end
			OP_MUL_SI: begin
				mul_a = OpW'(integral_q);
				mul_b = OpW'(cfg.speed_gain_i);
			end
			OP_MUL_TP: begin
				mul_a = OpW'(tilt_q);
				mul_b = OpW'(cfg.tilt_gain_p);
			end
			OP_MUL_TD: begin
				mul_a = OpW'(rate_q);
				mul_b = OpW'(cfg.tilt_gain_d);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;

		// Round to nearest, ties away from zero, then drop eight bits.
		p_rnd = prod_q + (prod_q[ProdW-1] ? ProdW'(127) : ProdW'(128));
		t_sum = acc_q + prod_q;

		i_sum = (IntW+2)'(integral_q) + (IntW+2)'(err16_q);
		i_lim = (IntW+2)'({1'b0, cfg.integral_limit});

		a_rnd = acc_q + (acc_q[ProdW-1] ? ProdW'(64'h7FFF_FFFF) : ProdW'(64'h8000_0000));
		a_sh = a_rnd >>> 32;
		if (a_sh > ProdW'(64'sh7FFF_FFFF)) begin
			drive_sat = 32'sh7FFF_FFFF;
		end else if (a_sh < -ProdW'(64'sh8000_0000)) begin
			drive_sat = 32'sh8000_0000;
		end else begin
			drive_sat = a_sh[DriveW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			integral_q <= '0;
			tipped_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: tipped_q <= tipped_now;
				OP_AVG: avg_q <= $signed(neg_q ? (~quot_q + AvgW'(1)) : quot_q);
				OP_TGT: begin
					if (i_sum > i_lim) begin
						integral_q <= IntW'(i_lim);
					end else if (i_sum < -i_lim) begin
						integral_q <= IntW'(-i_lim);
					end else begin
						integral_q <= IntW'(i_sum);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				angle_q <= item.pitch_angle;
				rate_q <= item.pitch_rate;
				lr3_q <= lr3;
			end
			OP_NUM: num_q <= num;
			OP_MAG: begin
				neg_q <= num_q[NumW-1];
				mag_q <= num_q[NumW-1] ? (MagW'(5) - num48) : (num48 + MagW'(5));
				rem_q <= '0;
				quot_q <= '0;
			end
			OP_DIV: begin
				mag_q <= mag_q << 8;
				rem_q <= drem[3:0];
				quot_q <= {quot_q[AvgW-9:0], qdig};
			end
			OP_AVG: begin
				// The speed error is the negated average, so its sign is the inverse.
				err8_q <= neg_q ? m8 : -m8;
				err16_q <= neg_q ? m16 : -m16;
			end
			OP_MUL_SP: prod_q <= mul_p;
			OP_MUL_SI: begin
				prod_q <= mul_p;
				acc_q <= p_rnd >>> 8;
			end
			OP_TGT: begin
				if (t_sum > ProdW'(TargetLimit)) begin
					target_q <= TargetLimit;
				end else if (t_sum < -ProdW'(TargetLimit)) begin
					target_q <= -TargetLimit;
				end else begin
					target_q <= TargetW'(t_sum);
				end
			end
			OP_TERR: tilt_q <= TiltW'(target_q) - (TiltW'(cfg.tilt_offset) <<< 8)
				+ (TiltW'(angle_q) <<< 8);
			OP_MUL_TP: prod_q <= mul_p;
			OP_MUL_TD: begin
				acc_q <= prod_q;
				prod_q <= mul_p;
			end
			// The rate enters negated, so its term is subtracted.
			OP_SUM: acc_q <= acc_q - (prod_q <<< 8);
			OP_OUT: begin
				result_q.drive <= tipped_q ? '0 : drive_sat;
				result_q.tipped_over <= tipped_q;
			end
			default: ;
		endcase
	end

endmodule

@@ src/bcc_ctrl.sv @@
// Sequencer of the balance cascade controller: steps the datapath through
// one update and owns the handshakes. Depends on bcc_pkg.
module bcc_ctrl import bcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	output logic       result_valid,
	input  logic       result_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_NUM,
		S_MAG,
		S_DIV,
		S_AVG,
		S_MUL_SP,
		S_MUL_SI,
		S_TGT,
		S_TERR,
		S_MUL_TP,
		S_MUL_TD,
		S_SUM,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [DivCntW-1:0]   cnt_q;
	logic                 result_valid_q;
	logic                 out_free;

	assign item_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign out_free = !result_valid_q || !result_stall;

	always_comb begin
		case (state_q)
			S_IDLE:   cmd.op = item_valid ? OP_LOAD : OP_NONE;
			S_NUM:    cmd.op = status.tipped ? OP_NONE : OP_NUM;
			S_MAG:    cmd.op = OP_MAG;
			S_DIV:    cmd.op = OP_DIV;
			S_AVG:    cmd.op = OP_AVG;
			S_MUL_SP: cmd.op = OP_MUL_SP;
			S_MUL_SI: cmd.op = OP_MUL_SI;
			S_TGT:    cmd.op = OP_TGT;
			S_TERR:   cmd.op = OP_TERR;
			S_MUL_TP: cmd.op = OP_MUL_TP;
			S_MUL_TD: cmd.op = OP_MUL_TD;
			S_SUM:    cmd.op = OP_SUM;
			S_OUT:    cmd.op = out_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_NUM;
					end
				end
				// A tipped item skips all state updates.
				S_NUM: state_q <= status.tipped ? S_OUT : S_MAG;
				S_MAG: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + DivCntW'(1);
					if (cnt_q == DivCntW'(DivSteps - 1)) begin
						state_q <= S_AVG;
					end
				end
				S_AVG:    state_q <= S_MUL_SP;
				S_MUL_SP: state_q <= S_MUL_SI;
				S_MUL_SI: state_q <= S_TGT;
				S_TGT:    state_q <= S_TERR;
				S_TERR:   state_q <= S_MUL_TP;
				S_MUL_TP: state_q <= S_MUL_TD;
				S_MUL_TD: state_q <= S_SUM;
				S_SUM:    state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ src/balance_cascade_controller_unit.sv @@
// Top level of the balance cascade controller: register bank, sequencer and datapath.
// Depends on bcc_pkg, bcc_cfg, bcc_ctrl, bcc_dp and the assertion macro header.
//
//   channel   direction   handshake              word
//   item      in          item_valid/item_stall  pitch angle, pitch rate, wheel drives
//   result    out         result_valid/result_stall  drive, tipped_over
//   cfg       in          cfg_valid/cfg_ready    register index and write data
//
// An upright item runs the byte-wide divide by ten (6 steps) and makes four passes
// through the one shared 33x33 multiplier before the next item is accepted; a tipped
// item skips both and goes straight to the output step.
// Reset restores the register defaults and clears the speed average and integral.
// A finished word waits in the output register; a stalled result only holds the
// sequencer in its last step once the next word is ready.
`include "balance_cascade_controller_unit_macros.svh"
module balance_cascade_controller_unit import bcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  item_t               item,
	output logic                result_valid,
	input  logic                result_stall,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	bcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	bcc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.cfg    (cfg),
		.status (status),
		.result (result)
	);

	// Only one word is in flight: an accepted word blocks the next one.
	`BCC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)
	// A new result word only appears at the end of work on an item.
	`BCC_ASSERT_IMP(a_result_from_work, clk, arst_n, $rose(result_valid), $past(item_stall))
	// A tipped result never carries drive.
	`BCC_ASSERT_IMP(a_tipped_zero, clk, arst_n, result_valid && result.tipped_over, result.drive == '0)

endmodule

@@ test/balance_cascade_controller_unit_tb.sv @@
// Self-checking testbench for balance_cascade_controller_unit: directed and random
// sensor samples under several gain settings, with a bit-exact drive predictor.
// Depends on bcc_pkg and the balance_cascade_controller_unit RTL.
module balance_cascade_controller_unit_tb;
	import bcc_pkg::*;

	localparam int ClkPeriod     = 10;
	localparam int TimeoutCycles = 600000;
	localparam int RandomPhases  = 8;
	localparam int PhaseSamples  = 240;
	localparam int BiasSpan      = 40;
	localparam int DrainCycles   = 40;
	localparam int AngleSpan     = 46080;
	localparam int UprightSpan   = 15360;
	localparam int PwmMax        = 8388607;
	localparam int PwmMin        = -8388608;

	// Predicts the drive word for each accepted sample and compares the results.
	class drive_scoreboard;
		cfg_t    gains;
		longint  speed_avg;   // Q24.16 counts
		longint  speed_sum;   // integer counts
		result_t want_drives[$];
		int      samples;
		int      tipped_count;
		int      checked;
		int      mismatches;

		function new();
			gains.speed_gain_p   = SpeedGainPReset;
			gains.speed_gain_i   = SpeedGainIReset;
			gains.integral_limit = IntLimitReset;
			gains.tilt_gain_p    = TiltGainPReset;
			gains.tilt_gain_d    = TiltGainDReset;
			gains.tilt_offset    = TiltOffsetReset;
			speed_avg = 0;
			speed_sum = 0;
			samples = 0;
			tipped_count = 0;
			checked = 0;
			mismatches = 0;
		endfunction

		// Rounding is to nearest with ties away from zero throughout.
		static function longint round_shift(longint v, int unsigned s);
			longint unsigned m;
			m = (v < 0) ? longint'(-v) : v;
			m = (m + (64'd1 << (s - 1))) >> s;
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		static function longint round_div10(longint v);
			longint unsigned m;
			m = (v < 0) ? longint'(-v) : v;
			m = (m + 5) / 10;
			return (v < 0) ? -longint'(m) : longint'(m);
		endfunction

		static function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				REG_SPEED_GAIN_P: gains.speed_gain_p = data;
				REG_SPEED_GAIN_I: gains.speed_gain_i = data;
				REG_INT_LIMIT:    gains.integral_limit = data[LimitW-1:0];
				REG_TILT_GAIN_P:  gains.tilt_gain_p = data;
				REG_TILT_GAIN_D:  gains.tilt_gain_d = data;
				REG_TILT_OFFSET:  gains.tilt_offset = data[OffsetW-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(item_t s);
			longint  angle, rate, wheels, lim, tilt_lim;
			longint  err, target, tilt_err, acc, drive;
			result_t want;
			angle    = longint'($signed(s.pitch_angle));
			rate     = longint'($signed(s.pitch_rate));
			wheels   = longint'($signed(s.left_pwm)) + longint'($signed(s.right_pwm));
			lim      = longint'($unsigned(gains.integral_limit));
			tilt_lim = longint'(TiltLimit);
			samples++;
			want.tipped_over = 1'b0;
			if (angle > tilt_lim || angle < -tilt_lim) begin
				// Past the tip-over limit the drive is cut and the loops freeze.
				want.drive = '0;
				want.tipped_over = 1'b1;
				tipped_count++;
			end else begin
				speed_avg = round_div10(7 * speed_avg + 3 * wheels * 32768);
				err = -speed_avg;
				target = round_shift(round_shift(err, 8) *
					longint'($signed(gains.speed_gain_p)), 8) +
					speed_sum * longint'($signed(gains.speed_gain_i));
				target = clamp(target, -longint'(TargetLimit), longint'(TargetLimit));
				speed_sum = clamp(speed_sum + round_shift(err, 16), -lim, lim);
				tilt_err = target - longint'($signed(gains.tilt_offset)) * 256 + angle * 256;
				acc = tilt_err * longint'($signed(gains.tilt_gain_p)) -
					rate * longint'($signed(gains.tilt_gain_d)) * 256;
				drive = clamp(round_shift(acc, 32), -64'sd2147483648, 64'sd2147483647);
				want.drive = drive[DriveW-1:0];
			end
			want_drives.push_back(want);
		endfunction

		function void check_drive(result_t got);
			result_t want;
			if (want_drives.size() == 0) begin
				$display("%0t: drive word with no sample pending, got drive %0d tipped %0b",
					$time, got.drive, got.tipped_over);
				mismatches++;
				return;
			end
			want = want_drives.pop_front();
			checked++;
			if (got.drive !== want.drive) begin
				$display("%0t: drive mismatch, expected %0d, got %0d",
					$time, want.drive, got.drive);
				mismatches++;
			end
			if (got.tipped_over !== want.tipped_over) begin
				$display("%0t: tipped_over mismatch, expected %0b, got %0b",
					$time, want.tipped_over, got.tipped_over);
				mismatches++;
			end
		endfunction

		function int pending();
			return want_drives.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	drive_scoreboard rig;
	int gap_pct = 0;
	int stall_pct = 0;
	bit quiet = 1'b0;
	int stall_left = 0;
	int settings = 0;

	balance_cascade_controller_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// The receiver stalls in bursts of random length.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(4);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			rig.check_drive(result);
	end

	function automatic item_t make_sample(int angle, int rate, int left, int right);
		item_t s;
		s.pitch_angle = angle[AngleW-1:0];
		s.pitch_rate  = rate[RateW-1:0];
		s.left_pwm    = left[PwmW-1:0];
		s.right_pwm   = right[PwmW-1:0];
		return s;
	endfunction

	function automatic int near_bias(int bias);
		int v;
		if ($urandom_range(99) < 70) begin
			v = bias + int'($urandom_range(8191)) - 4096;
			return (v > PwmMax) ? PwmMax : ((v < PwmMin) ? PwmMin : v);
		end
		return int'($urandom());
	endfunction

	function automatic item_t random_sample(int bias);
		int pick, angle, rate;
		pick = $urandom_range(99);
		if (pick < 8) begin
			angle = $urandom_range(AngleSpan, UprightSpan + 1);
			if ($urandom_range(1))
				angle = -angle;
		end else if (pick < 14) begin
			angle = int'($urandom_range(2 * AngleSpan)) - AngleSpan;
		end else begin
			angle = int'($urandom_range(2 * UprightSpan)) - UprightSpan;
		end
		rate = ($urandom_range(99) < 60) ? int'($urandom_range(32767)) - 16384
			: int'($urandom());
		return make_sample(angle, rate, near_bias(bias), near_bias(bias));
	endfunction

	function automatic cfg_t gains_for_phase(int p);
		cfg_t g;
		case (p)
			1: begin
				g.speed_gain_p   = 32'h7fff_ffff;
				g.speed_gain_i   = 32'h7fff_ffff;
				g.integral_limit = '1;
				g.tilt_gain_p    = 32'h7fff_ffff;
				g.tilt_gain_d    = 32'h8000_0000;
				g.tilt_offset    = OffsetW'(AngleSpan);
			end
			2: begin
				g.speed_gain_p   = 32'h8000_0000;
				g.speed_gain_i   = 32'h8000_0000;
				g.integral_limit = '0;
				g.tilt_gain_p    = 32'h8000_0000;
				g.tilt_gain_d    = 32'h7fff_ffff;
				g.tilt_offset    = OffsetW'(-AngleSpan);
			end
			3, 5: begin
				// Gains of the order a real robot would use.
				g.speed_gain_p   = int'($urandom_range(1 << 20)) - (1 << 19);
				g.speed_gain_i   = int'($urandom_range(8191)) - 4096;
				g.integral_limit = LimitW'($urandom_range(1 << 20));
				g.tilt_gain_p    = int'($urandom_range(1 << 27)) - (1 << 26);
				g.tilt_gain_d    = int'($urandom_range(1 << 29)) - (1 << 28);
				g.tilt_offset    = OffsetW'(int'($urandom_range(6000)) - 3000);
			end
			default: begin
				g.speed_gain_p   = $urandom();
				g.speed_gain_i   = $urandom();
				g.integral_limit = LimitW'($urandom());
				g.tilt_gain_p    = $urandom();
				g.tilt_gain_d    = $urandom();
				g.tilt_offset    = OffsetW'($urandom());
			end
		endcase
		return g;
	endfunction

	// Holds cfg_valid high across a run of writes; the caller lowers it.
	task automatic put_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		rig.set_reg(idx, data);
	endtask

	task automatic load_gains(cfg_t g);
		logic [CfgDataW-1:0] word;
		logic [CfgIdxW-1:0]  spare;
		put_reg(REG_SPEED_GAIN_P, g.speed_gain_p);
		put_reg(REG_SPEED_GAIN_I, g.speed_gain_i);
		word = $urandom();
		word[LimitW-1:0] = g.integral_limit;
		put_reg(REG_INT_LIMIT, word);
		// Writes to indexes past the last register must change nothing.
		spare = CfgIdxW'($urandom_range(REG_TILT_OFFSET + 1, (1 << CfgIdxW) - 1));
		put_reg(spare, $urandom());
		put_reg(REG_TILT_GAIN_P, g.tilt_gain_p);
		put_reg(REG_TILT_GAIN_D, g.tilt_gain_d);
		word = $urandom();
		word[OffsetW-1:0] = g.tilt_offset;
		put_reg(REG_TILT_OFFSET, word);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic send_item(item_t s);
		item_valid <= 1'b1;
		item <= s;
		do @(posedge clk); while (item_stall);
		rig.note_sample(s);
		if (!quiet && $urandom_range(99) < gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
	endtask

	// The sender holds off until every drive word is back and the block is idle.
	task automatic settle();
		item_valid <= 1'b0;
		while (rig.pending() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		int bias;
		rig = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 20;
		stall_pct = 20;
		send_item(make_sample(0, 0, 0, 0));
		send_item(make_sample(UprightSpan, 0, 0, 0));
		send_item(make_sample(-UprightSpan, 0, 0, 0));
		send_item(make_sample(UprightSpan + 1, 0, 0, 0));
		send_item(make_sample(-UprightSpan - 1, 0, 0, 0));
		send_item(make_sample(AngleSpan, PwmMax, PwmMax, PwmMax));
		send_item(make_sample(-AngleSpan, PwmMin, PwmMin, PwmMin));
		send_item(make_sample(0, PwmMax, 0, 0));
		send_item(make_sample(0, PwmMin, 0, 0));
		// Full drive in one direction pushes the target and the integral to their limits.
		repeat (6) send_item(make_sample(256, 1000, PwmMax, PwmMax));
		repeat (6) send_item(make_sample(-256, -1000, PwmMin, PwmMin));
		send_item(make_sample(100, -5, PwmMax, PwmMin));
		send_item(make_sample(-100, 5, PwmMin, PwmMax));
		send_item(make_sample(UprightSpan, PwmMax, PwmMin, PwmMax));
		send_item(make_sample(-UprightSpan, PwmMin, PwmMax, PwmMin));
		settle();

		for (int p = 0; p < RandomPhases; p++) begin
			load_gains(gains_for_phase(p));
			gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 20 : 45);
			stall_pct = (p % 4 == 1) ? 0 : ((p % 2 == 0) ? 20 : 45);
			quiet = (p == RandomPhases - 1);
			bias = 0;
			for (int i = 0; i < PhaseSamples; i++) begin
				if (i % BiasSpan == 0)
					bias = ($urandom_range(99) < 40) ? int'($urandom_range(2 * PwmMax + 1)) + PwmMin
						: int'($urandom_range(40000)) - 20000;
				send_item(random_sample(bias));
			end
			settle();
		end

		$display("Ran %0d samples, %0d of them past the tip-over limit, under %0d gain settings.",
			rig.samples, rig.tipped_count, settings + 1);
		$display("Compared %0d drive words; %0d mismatches, %0d still pending.",
			rig.checked, rig.mismatches, rig.pending());
		if (rig.mismatches == 0 && rig.pending() == 0) begin
			$display("** balance_cascade_controller_unit: PASSED **");
		end else begin
			$display("** balance_cascade_controller_unit: FAILED **");
		end
		$finish;
	end

	initial begin
		#(ClkPeriod * TimeoutCycles);
		$display("Timed out with %0d drive words pending.", rig.pending());
		$display("** balance_cascade_controller_unit: FAILED **");
		$finish;
	end

endmodule
